@@ rtl/bba_pkg.sv @@
`default_nettype none
// ============================================================================
// bba_pkg
// Shared types, codes and the microcode table of the bitmap block allocator.
// ============================================================================
package bba_pkg;

    // Fixed field widths of the request and response beats.
    localparam int IDX_OUT_W   = 10;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    // Entries per bitmap byte.
    localparam int ROW_BITS = 8;

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DFREE = 2'd2;

    // Microprogram addresses.
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] U_CLEAR = 4'd0;
    localparam logic [UPC_W-1:0] U_IDLE  = 4'd1;
    localparam logic [UPC_W-1:0] U_DISP  = 4'd2;
    localparam logic [UPC_W-1:0] U_SCAN  = 4'd3;
    localparam logic [UPC_W-1:0] U_PICK  = 4'd4;
    localparam logic [UPC_W-1:0] U_ALLOC = 4'd5;
    localparam logic [UPC_W-1:0] U_FULL  = 4'd6;
    localparam logic [UPC_W-1:0] U_FCHK  = 4'd7;
    localparam logic [UPC_W-1:0] U_FREE  = 4'd8;
    localparam logic [UPC_W-1:0] U_DFREE = 4'd9;
    localparam logic [UPC_W-1:0] U_OUT   = 4'd10;

    // Row pointer operations. PTR_INC_NT increments only when the branch falls through.
    localparam logic [1:0] PTR_HOLD   = 2'd0;
    localparam logic [1:0] PTR_LOAD   = 2'd1;
    localparam logic [1:0] PTR_INC    = 2'd2;
    localparam logic [1:0] PTR_INC_NT = 2'd3;

    // Bitmap write operations.
    localparam logic [1:0] WR_NONE    = 2'd0;
    localparam logic [1:0] WR_CLR_ROW = 2'd1;
    localparam logic [1:0] WR_SET_BIT = 2'd2;
    localparam logic [1:0] WR_CLR_BIT = 2'd3;

    // Free counter operations.
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_DEC  = 2'd1;
    localparam logic [1:0] CNT_INC  = 2'd2;

    // Result register operations.
    localparam logic [2:0] RES_NONE     = 3'd0;
    localparam logic [2:0] RES_ALLOC_OK = 3'd1;
    localparam logic [2:0] RES_FULL     = 3'd2;
    localparam logic [2:0] RES_FREE_OK  = 3'd3;
    localparam logic [2:0] RES_DFREE    = 3'd4;

    // Branch conditions.
    localparam logic [2:0] CC_ALWAYS   = 3'd0;
    localparam logic [2:0] CC_IN_BEAT  = 3'd1;
    localparam logic [2:0] CC_OP_FREE  = 3'd2;
    localparam logic [2:0] CC_DONE     = 3'd3;
    localparam logic [2:0] CC_FOUND    = 3'd4;
    localparam logic [2:0] CC_LAST     = 3'd5;
    localparam logic [2:0] CC_FREE_OK  = 3'd6;
    localparam logic [2:0] CC_OUT_ROOM = 3'd7;

    typedef struct packed {
        logic             take_in;
        logic             out_load;
        logic [1:0]       ptr_op;
        logic [1:0]       wr_op;
        logic [1:0]       cnt_op;
        logic [2:0]       res_op;
        logic [2:0]       cond;
        logic [UPC_W-1:0] jmp;
        logic [UPC_W-1:0] nxt;
    } ctrl_t;

    typedef struct packed {
        logic op_free;
        logic done;
        logic found;
        logic last_row;
        logic free_ok;
    } dp_flags_t;

    typedef struct packed {
        logic    in_beat;
        logic    out_room;
        dp_flags_t dp;
    } cond_flags_t;

    // Entry byte*8+bit sits under mask 0x80>>bit of its bitmap byte.
    function automatic logic [ROW_BITS-1:0] bit_mask(input logic [2:0] b);
        return 8'h80 >> b;
    endfunction

    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
        ctrl_t w;
        w = '{take_in: 1'b0, out_load: 1'b0, ptr_op: PTR_HOLD, wr_op: WR_NONE,
              cnt_op: CNT_HOLD, res_op: RES_NONE, cond: CC_ALWAYS,
              jmp: U_IDLE, nxt: U_IDLE};
        unique case (upc)
            U_CLEAR:
            begin
                w.wr_op  = WR_CLR_ROW;
                w.ptr_op = PTR_INC;
                w.cond   = CC_LAST;
                w.jmp    = U_IDLE;
                w.nxt    = U_CLEAR;
            end
            U_IDLE:
            begin
                w.take_in = 1'b1;
                w.ptr_op  = PTR_LOAD;
                w.cond    = CC_IN_BEAT;
                w.jmp     = U_DISP;
                w.nxt     = U_IDLE;
            end
            U_DISP:
            begin
                w.cond = CC_OP_FREE;
                w.jmp  = U_FCHK;
                w.nxt  = U_SCAN;
            end
            U_SCAN:
            begin
                w.ptr_op = PTR_INC_NT;
                w.cond   = CC_DONE;
                w.jmp    = U_PICK;
                w.nxt    = U_SCAN;
            end
            U_PICK:
            begin
                w.cond = CC_FOUND;
                w.jmp  = U_ALLOC;
                w.nxt  = U_FULL;
            end
            U_ALLOC:
            begin
                w.wr_op  = WR_SET_BIT;
                w.cnt_op = CNT_DEC;
                w.res_op = RES_ALLOC_OK;
                w.jmp    = U_OUT;
            end
            U_FULL:
            begin
                w.res_op = RES_FULL;
                w.jmp    = U_OUT;
            end
            U_FCHK:
            begin
                w.cond = CC_FREE_OK;
                w.jmp  = U_FREE;
                w.nxt  = U_DFREE;
            end
            U_FREE:
            begin
                w.wr_op  = WR_CLR_BIT;
                w.cnt_op = CNT_INC;
                w.res_op = RES_FREE_OK;
                w.jmp    = U_OUT;
            end
            U_DFREE:
            begin
                w.res_op = RES_DFREE;
                w.jmp    = U_OUT;
            end
            U_OUT:
            begin
                w.out_load = 1'b1;
                w.cond     = CC_OUT_ROOM;
                w.jmp      = U_IDLE;
                w.nxt      = U_OUT;
            end
            default:
            begin
                w.jmp = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bba_useq.sv @@
`default_nettype none
// ============================================================================
// bba_useq
// Microsequencer: step counter, control word table and conditional branch.
// ============================================================================
module bba_useq
    import bba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cond_flags_t flags,
    output ctrl_t            ctl,
    output logic             taken
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;

    assign ctl = ucode_rom(upc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            CC_ALWAYS:   taken = 1'b1;
            CC_IN_BEAT:  taken = flags.in_beat;
            CC_OP_FREE:  taken = flags.dp.op_free;
            CC_DONE:     taken = flags.dp.done;
            CC_FOUND:    taken = flags.dp.found;
            CC_LAST:     taken = flags.dp.last_row;
            CC_FREE_OK:  taken = flags.dp.free_ok;
            CC_OUT_ROOM: taken = flags.out_room;
            default:     taken = 1'b1;
        endcase
    end

    assign upc_next = taken ? ctl.jmp : ctl.nxt;

    // Reset starts the clearing pass over the bitmap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= U_OUT)
        else $error("step counter left the program");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == U_OUT && !flags.out_room) |=> upc_reg == U_OUT)
        else $error("result step left while the output was full");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == U_IDLE && flags.in_beat) |=> upc_reg == U_DISP)
        else $error("accepted request was not dispatched");

endmodule
`default_nettype wire

@@ rtl/bba_datapath.sv @@
`default_nettype none
// ============================================================================
// bba_datapath
// Bitmap memory, row pointer, free counter and result registers.
// ============================================================================
module bba_datapath
    import bba_pkg::*;
#(
    parameter int NUM_ENTRIES = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ctrl_t                    ctl,
    input  wire logic                     taken,
    input  wire logic                     in_beat,
    input  wire logic                     operation,
    input  wire logic [IDX_OUT_W-1:0]     entry_index,
    output dp_flags_t                     flags,
    output logic [$clog2(NUM_ENTRIES)-1:0]   res_idx,
    output logic [STATUS_W-1:0]           res_status,
    output logic [$clog2(NUM_ENTRIES+1)-1:0] free_cnt
);

    localparam int ROWS  = (NUM_ENTRIES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_reg;
    logic [ROW_BITS-1:0] wr_data;

    logic [ROW_W-1:0]     ptr_reg;
    logic [ROW_W-1:0]     ptr_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 op_reg;
    logic [IDX_OUT_W-1:0] idx_reg;
    logic [IDX_W-1:0]     res_idx_reg;
    logic [STATUS_W-1:0]  res_status_reg;

    logic        found;
    logic [2:0]  found_bit;
    logic [31:0] row_base;
    logic        in_range;
    logic        last_row;
    logic        free_ok;

    assign row_base = 32'(ptr_reg) << 3;
    assign last_row = (ptr_reg == ROW_W'(ROWS - 1));
    assign in_range = (32'(idx_reg) < NUM_ENTRIES);
    assign free_ok  = in_range && ((rd_reg & bit_mask(idx_reg[2:0])) != '0);

    // Lowest free entry of the current row; entries past the end count as used.
    always_comb
    begin
        found     = 1'b0;
        found_bit = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (!rd_reg[ROW_BITS-1-b] && ((row_base + 32'(b)) < NUM_ENTRIES))
            begin
                found     = 1'b1;
                found_bit = 3'(b);
            end
        end
    end

    assign flags = '{op_free: op_reg == OP_FREE, done: found || last_row,
                     found: found, last_row: last_row, free_ok: free_ok};

    always_comb
    begin
        unique case (ctl.ptr_op)
            PTR_HOLD:   ptr_next = ptr_reg;
            PTR_LOAD:   ptr_next = (operation == OP_FREE)
                                   ? ROW_W'(32'(entry_index) >> 3) : '0;
            PTR_INC:    ptr_next = ptr_reg + 1'b1;
            PTR_INC_NT: ptr_next = taken ? ptr_reg : ptr_reg + 1'b1;
            default:    ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctl.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_DEC:  cnt_next = cnt_reg - 1'b1;
            CNT_INC:  cnt_next = cnt_reg + 1'b1;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctl.wr_op)
            WR_CLR_ROW: wr_data = '0;
            WR_SET_BIT: wr_data = rd_reg | bit_mask(found_bit);
            WR_CLR_BIT: wr_data = rd_reg & ~bit_mask(idx_reg[2:0]);
            default:    wr_data = rd_reg;
        endcase
    end

    // The read follows the pointer's next value, so rd_reg holds the row under the
    // current pointer, but does not yet show a write made to that same row.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_op != WR_NONE)
        begin
            mem[ptr_reg] <= wr_data;
        end
        rd_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            cnt_reg <= CNT_W'(NUM_ENTRIES);
        end
        else
        begin
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_in && in_beat)
        begin
            op_reg  <= operation;
            idx_reg <= entry_index;
        end
        unique case (ctl.res_op)
            RES_ALLOC_OK:
            begin
                res_idx_reg    <= IDX_W'(row_base + 32'(found_bit));
                res_status_reg <= ST_OK;
            end
            RES_FULL:
            begin
                res_idx_reg    <= '0;
                res_status_reg <= ST_FULL;
            end
            RES_FREE_OK:
            begin
                res_idx_reg    <= '0;
                res_status_reg <= ST_OK;
            end
            RES_DFREE:
            begin
                res_idx_reg    <= '0;
                res_status_reg <= ST_DFREE;
            end
            default:
            begin
                res_idx_reg    <= res_idx_reg;
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    assign res_idx    = res_idx_reg;
    assign res_status = res_status_reg;
    assign free_cnt   = cnt_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= NUM_ENTRIES)
        else $error("free count above the number of entries");

    a_set_found: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_op == WR_SET_BIT |-> found && cnt_reg != '0)
        else $error("allocation without a free entry");

    a_clr_used: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_op == WR_CLR_BIT |-> free_ok && 32'(cnt_reg) < NUM_ENTRIES)
        else $error("free of an entry that was not in use");

endmodule
`default_nettype wire

@@ rtl/bitmap_block_allocator.sv @@
`default_nettype none
// ============================================================================
// bitmap_block_allocator
// First-fit bitmap allocator run by a microcoded sequencer over a byte-wide
// bitmap memory, with a registered response stage.
// ============================================================================
//
//  Channel   Direction  Handshake            Beat contents
//  --------  ---------  -------------------  ---------------------------------
//  request   in         in_valid / in_stall  operation, entry_index
//  response  out        out_valid / out_stall allocated_index, status, free_count
//
//  An allocate runs dispatch, a scan of one bitmap byte per cycle through
//  the memory read port (up to 128 at the default size), a pick step, the
//  allocate or full step and the output step; a free runs dispatch, a check,
//  the free or double-free step and the output step. After reset a clearing
//  pass writes one bitmap byte per cycle, all 128 at the default size, while
//  in_stall stays high. A stalled response holds the sequencer in U_OUT.
//
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_ENTRIES = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [IDX_OUT_W-1:0]   entry_index,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [IDX_OUT_W-1:0]        allocated_index,
    output logic [STATUS_W-1:0]         status,
    output logic [COUNT_OUT_W-1:0]      free_count
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

    ctrl_t       ctl;
    logic        taken;
    dp_flags_t   dp_flags;
    cond_flags_t flags;
    logic        in_beat;
    logic        out_room;
    logic        out_load;

    logic [IDX_W-1:0]    res_idx;
    logic [STATUS_W-1:0] res_status;
    logic [CNT_W-1:0]    free_cnt;

    logic                   out_valid_reg;
    logic [IDX_OUT_W-1:0]   out_idx_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [31:0]            idx_wide;
    logic [31:0]            cnt_wide;

    assign in_stall = !ctl.take_in;
    assign in_beat  = in_valid && !in_stall;
    assign out_room = !out_valid_reg || !out_stall;
    assign out_load = ctl.out_load && out_room;
    assign flags    = '{in_beat: in_beat, out_room: out_room, dp: dp_flags};

    bba_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl),
        .taken (taken)
    );

    bba_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .taken       (taken),
        .in_beat     (in_beat),
        .operation   (operation),
        .entry_index (entry_index),
        .flags       (dp_flags),
        .res_idx     (res_idx),
        .res_status  (res_status),
        .free_cnt    (free_cnt)
    );

    assign idx_wide = 32'(res_idx);
    assign cnt_wide = 32'(free_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg    <= idx_wide[IDX_OUT_W-1:0];
            out_status_reg <= res_status;
            out_count_reg  <= cnt_wide[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign allocated_index = out_idx_reg;
    assign status          = out_status_reg;
    assign free_count      = out_count_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("second request taken while one is in flight");

    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("response register overwritten while stalled");

    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> !ctl.out_load)
        else $error("request accepted in the response step");

endmodule
`default_nettype wire
